// ===== design/pfmgpg_pkg.sv =====
// Shared types and constants for the PFM group pulse generator.
// Used by pfmgpg_ratio_search, pfmgpg_pattern and the top level; no dependencies.
`default_nettype none

package pfmgpg_pkg;

  // Field widths
  localparam int unsigned CountW  = 6;   // N1, N2, totals, max_total
  localparam int unsigned TargetW = 17;  // Q1.16 target, 65536 = 1.0
  localparam int unsigned FracW   = 16;  // fraction bits of the target
  localparam int unsigned TickW   = 8;   // tick counter
  localparam int unsigned ErrW    = 23;  // |N1*65536 - target*total|
  localparam int unsigned ProdW   = ErrW + CountW;  // error times a total

  // Constants of the pattern and the search
  localparam int unsigned MinTotal      = 3;   // smallest total tried
  localparam int unsigned MaxTotalReset = 12;  // reset of max_total
  localparam int unsigned FastReset     = 2;   // N1 after reset
  localparam int unsigned SlowReset     = 1;   // N2 after reset
  localparam int unsigned DefaultN1     = 1;   // answer when nothing is tried
  localparam int unsigned DefaultN2     = 2;

  // Item kinds carried on the mode field
  localparam logic ModeTick  = 1'b0;
  localparam logic ModeRatio = 1'b1;

  // Search result handed to the pattern
  typedef struct packed {
    logic              done;
    logic [CountW-1:0] n1;
    logic [CountW-1:0] n2;
  } search_res_t;

  // Pattern status shown on the result channel
  typedef struct packed {
    logic              level;
    logic              slow_phase;
    logic [CountW-1:0] fast_count;
    logic [CountW-1:0] slow_count;
  } pat_stat_t;

endpackage

`default_nettype wire

// ===== design/pfmgpg_ratio_search.sv =====
// Ratio search: picks odd N1 and even N2 whose N1/total is closest to a target.
// One shared 23x6 multiplier under a small sequencer; uses pfmgpg_pkg.
`default_nettype none

module pfmgpg_ratio_search (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [pfmgpg_pkg::TargetW-1:0]      target_i,
  input  logic [pfmgpg_pkg::CountW-1:0]       limit_i,
  output logic                                busy_o,
  output pfmgpg_pkg::search_res_t             res_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BPROD,
    S_ERR,
    S_LHS,
    S_RHS,
    S_UPD,
    S_DONE
  } state_e;

  state_e                             state_q;
  logic [pfmgpg_pkg::TargetW-1:0]     target_q;
  logic [pfmgpg_pkg::CountW-1:0]      limit_q;
  logic [pfmgpg_pkg::CountW-1:0]      tot_q;
  logic [pfmgpg_pkg::CountW-1:0]      n1_q;
  logic [pfmgpg_pkg::ProdW-1:0]       prod_q;
  logic [pfmgpg_pkg::ErrW-1:0]        err_q;
  logic [pfmgpg_pkg::ProdW-1:0]       lhs_q;
  logic [pfmgpg_pkg::ProdW-1:0]       rhs_q;
  logic [pfmgpg_pkg::ErrW-1:0]        lead_err_q;
  logic [pfmgpg_pkg::CountW-1:0]      best_tot_q;
  logic [pfmgpg_pkg::CountW-1:0]      best_n1_q;
  logic [pfmgpg_pkg::CountW-1:0]      best_n2_q;
  logic                               have_q;

  logic [pfmgpg_pkg::ErrW-1:0]        mul_a;
  logic [pfmgpg_pkg::CountW-1:0]      mul_b;
  logic [pfmgpg_pkg::ProdW-1:0]       mul_p;
  logic [pfmgpg_pkg::ErrW-1:0]        a_val;
  logic [pfmgpg_pkg::ErrW-1:0]        b_val;
  logic [pfmgpg_pkg::ErrW-1:0]        err_val;
  logic [pfmgpg_pkg::CountW:0]        n1_nx;
  logic [pfmgpg_pkg::CountW:0]        tot_nx;
  logic                               last_in_tot;
  logic                               finish;
  logic                               better;

  // Route the shared multiplier by step
  always_comb begin
    unique case (state_q)
      S_BPROD: begin
        mul_a = pfmgpg_pkg::ErrW'(target_q);
        mul_b = tot_q;
      end
      S_LHS: begin
        mul_a = err_q;
        mul_b = best_tot_q;
      end
      S_RHS: begin
        mul_a = lead_err_q;
        mul_b = tot_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = pfmgpg_pkg::ProdW'(mul_a) * pfmgpg_pkg::ProdW'(mul_b);

  // Absolute error of the candidate, scaled by its total
  assign a_val   = pfmgpg_pkg::ErrW'({n1_q, {pfmgpg_pkg::FracW{1'b0}}});
  assign b_val   = prod_q[pfmgpg_pkg::ErrW-1:0];
  assign err_val = (a_val >= b_val) ? (a_val - b_val) : (b_val - a_val);

  // Step to the next candidate: N1 odd, total odd, N2 at least two
  assign n1_nx       = {1'b0, n1_q} + (pfmgpg_pkg::CountW+1)'(2);
  assign tot_nx      = {1'b0, tot_q} + (pfmgpg_pkg::CountW+1)'(2);
  assign last_in_tot = (n1_nx >= {1'b0, tot_q});
  assign finish      = last_in_tot && (tot_nx > {1'b0, limit_q});
  assign better      = !have_q || (lhs_q < rhs_q);

  // Sequencer and best-so-far registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      have_q     <= 1'b0;
      best_n1_q  <= pfmgpg_pkg::CountW'(pfmgpg_pkg::DefaultN1);
      best_n2_q  <= pfmgpg_pkg::CountW'(pfmgpg_pkg::DefaultN2);
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            target_q  <= target_i;
            limit_q   <= limit_i;
            tot_q     <= pfmgpg_pkg::CountW'(pfmgpg_pkg::MinTotal);
            n1_q      <= pfmgpg_pkg::CountW'(pfmgpg_pkg::DefaultN1);
            have_q    <= 1'b0;
            best_n1_q <= pfmgpg_pkg::CountW'(pfmgpg_pkg::DefaultN1);
            best_n2_q <= pfmgpg_pkg::CountW'(pfmgpg_pkg::DefaultN2);
            if (limit_i < pfmgpg_pkg::CountW'(pfmgpg_pkg::MinTotal)) begin
              state_q <= S_DONE;
            end else begin
              state_q <= S_BPROD;
            end
          end
        end
        S_BPROD: begin
          prod_q  <= mul_p;
          state_q <= S_ERR;
        end
        S_ERR: begin
          err_q   <= err_val;
          state_q <= S_LHS;
        end
        S_LHS: begin
          lhs_q   <= mul_p;
          state_q <= S_RHS;
        end
        S_RHS: begin
          rhs_q   <= mul_p;
          state_q <= S_UPD;
        end
        S_UPD: begin
          // keep the earlier candidate on a tie
          if (better) begin
            have_q     <= 1'b1;
            lead_err_q <= err_q;
            best_tot_q <= tot_q;
            best_n1_q  <= n1_q;
            best_n2_q  <= tot_q - n1_q;
          end
          if (finish) begin
            state_q <= S_DONE;
          end else if (last_in_tot) begin
            tot_q   <= tot_nx[pfmgpg_pkg::CountW-1:0];
            n1_q    <= pfmgpg_pkg::CountW'(pfmgpg_pkg::DefaultN1);
            state_q <= S_BPROD;
          end else begin
            n1_q    <= n1_nx[pfmgpg_pkg::CountW-1:0];
            state_q <= S_BPROD;
          end
        end
        S_DONE: begin
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o     = (state_q != S_IDLE);
  assign res_o.done = (state_q == S_DONE);
  assign res_o.n1   = best_n1_q;
  assign res_o.n2   = best_n2_q;

  // The answer always pairs an odd N1 with an even N2
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.done |-> (res_o.n1[0] == 1'b1) && (res_o.n2[0] == 1'b0))
    else $error("search answer breaks the N1 odd, N2 even rule");

  // Every candidate leaves room for N2 of at least two
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> ({1'b0, n1_q} + (pfmgpg_pkg::CountW+1)'(2) <= {1'b0, tot_q}))
    else $error("candidate N1 out of range for its total");

  // Done lasts one cycle and returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.done |=> !res_o.done && !busy_o)
    else $error("search done did not drop back to idle");

endmodule

`default_nettype wire

// ===== design/pfmgpg_pattern.sv =====
// Gate pattern: fast and slow groups, tick counter and the stored N1/N2.
// Uses pfmgpg_pkg; loaded from the ratio search.
`default_nettype none

module pfmgpg_pattern (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          tick_i,
  input  logic                          load_i,
  input  logic [pfmgpg_pkg::CountW-1:0] n1_i,
  input  logic [pfmgpg_pkg::CountW-1:0] n2_i,
  output pfmgpg_pkg::pat_stat_t         stat_o
);

  logic                          slow_q;
  logic [pfmgpg_pkg::TickW-1:0]  tick_q;
  logic [1:0]                    mod3_q;
  logic                          level_q;
  logic [pfmgpg_pkg::CountW-1:0] fast_cnt_q;
  logic [pfmgpg_pkg::CountW-1:0] slow_cnt_q;

  logic [pfmgpg_pkg::TickW-1:0]  tick_inc;
  logic [pfmgpg_pkg::TickW-1:0]  slow_limit;
  logic [1:0]                    mod3_inc;

  // Tick count and its value mod three in the slow group
  assign tick_inc   = tick_q + pfmgpg_pkg::TickW'(1);
  assign slow_limit = pfmgpg_pkg::TickW'({slow_cnt_q, 1'b0})
                    + pfmgpg_pkg::TickW'(slow_cnt_q);
  assign mod3_inc   = (mod3_q == 2'd2) ? 2'd0 : (mod3_q + 2'd1);

  // Advance the pattern on a tick, take new counts on a load
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slow_q     <= 1'b0;
      tick_q     <= '0;
      mod3_q     <= '0;
      level_q    <= 1'b0;
      fast_cnt_q <= pfmgpg_pkg::CountW'(pfmgpg_pkg::FastReset);
      slow_cnt_q <= pfmgpg_pkg::CountW'(pfmgpg_pkg::SlowReset);
    end else begin
      priority if (load_i) begin
        fast_cnt_q <= n1_i;
        slow_cnt_q <= n2_i;
      end else if (tick_i) begin
        if (!slow_q) begin
          level_q <= ~level_q;
          if (tick_inc >= pfmgpg_pkg::TickW'(fast_cnt_q)) begin
            slow_q <= 1'b1;
            tick_q <= '0;
            mod3_q <= '0;
          end else begin
            tick_q <= tick_inc;
          end
        end else begin
          if (mod3_inc == 2'd0) begin
            level_q <= ~level_q;
          end
          if (tick_inc >= slow_limit) begin
            slow_q <= 1'b0;
            tick_q <= '0;
          end else begin
            tick_q <= tick_inc;
            mod3_q <= mod3_inc;
          end
        end
      end
    end
  end

  assign stat_o.level      = level_q;
  assign stat_o.slow_phase = slow_q;
  assign stat_o.fast_count = fast_cnt_q;
  assign stat_o.slow_count = slow_cnt_q;

endmodule

`default_nettype wire

// ===== design/pfmgpg_group_pulse_generator_top.sv =====
// Top level of one PFM group pulse generator channel.
// Instantiates pfmgpg_ratio_search and pfmgpg_pattern; uses pfmgpg_pkg.
`default_nettype none

//  channel | handshake                 | payload
//  --------+---------------------------+---------------------------------------
//  in      | in_valid_i / in_ready_o   | mode_i, target_ratio_i
//  out     | out_valid_o / out_ready_i | high_side_o, low_side_o,
//          |                           | in_slow_group_o, fast_pulses_o,
//          |                           | slow_pulses_o
//  cfg     | cfg_we_i                  | cfg_wdata_i (max_total)
//
// A tick item advances the pattern and sets the finished flag; the output register
// then captures the pattern status. A ratio item runs the search over C candidates,
// C being the sum of (t-1)/2 over odd totals t from 3 to max_total (15 at reset,
// 496 at 63); each candidate takes five steps, three of which share one multiplier.
// Reset: max_total 12, N1 2, N2 1, fast group, pattern level low; the output register
// has no reset. It holds one result while the next item runs; its result waits until the register frees.

module pfm_group_pulse_generator_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pfmgpg_pkg::CountW-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           mode_i,
  input  logic [pfmgpg_pkg::TargetW-1:0] target_ratio_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           high_side_o,
  output logic                           low_side_o,
  output logic                           in_slow_group_o,
  output logic [pfmgpg_pkg::CountW-1:0]  fast_pulses_o,
  output logic [pfmgpg_pkg::CountW-1:0]  slow_pulses_o
);

  logic [pfmgpg_pkg::CountW-1:0] max_total_q;
  logic                          fin_q;
  logic                          out_valid_q;
  logic                          high_q;
  logic                          low_q;
  logic                          slow_grp_q;
  logic [pfmgpg_pkg::CountW-1:0] fast_q;
  logic [pfmgpg_pkg::CountW-1:0] slow_q;

  logic                          in_fire;
  logic                          tick;
  logic                          start;
  logic                          srch_busy;
  logic                          load_out;
  pfmgpg_pkg::search_res_t       srch_res;
  pfmgpg_pkg::pat_stat_t         stat;

  // Accept an item only with no search running and no result waiting inside
  assign in_ready_o = !fin_q && !srch_busy;
  assign in_fire    = in_valid_i && in_ready_o;
  assign tick       = in_fire && (mode_i == pfmgpg_pkg::ModeTick);
  assign start      = in_fire && (mode_i == pfmgpg_pkg::ModeRatio);
  assign load_out   = fin_q && (!out_valid_q || out_ready_i);

  pfmgpg_ratio_search u_search (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .target_i (target_ratio_i),
    .limit_i  (max_total_q),
    .busy_o   (srch_busy),
    .res_o    (srch_res)
  );

  pfmgpg_pattern u_pattern (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tick_i (tick),
    .load_i (srch_res.done),
    .n1_i   (srch_res.n1),
    .n2_i   (srch_res.n2),
    .stat_o (stat)
  );

  // Hold the configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_total_q <= pfmgpg_pkg::CountW'(pfmgpg_pkg::MaxTotalReset);
    end else if (cfg_we_i) begin
      max_total_q <= cfg_wdata_i;
    end
  end

  // Track the finished item and the output register's valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (tick || srch_res.done) begin
        fin_q <= 1'b1;
      end else if (load_out) begin
        fin_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the pattern status into the output register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      high_q     <= stat.level;
      low_q      <= ~stat.level;
      slow_grp_q <= stat.slow_phase;
      fast_q     <= stat.fast_count;
      slow_q     <= stat.slow_count;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign high_side_o     = high_q;
  assign low_side_o      = low_q;
  assign in_slow_group_o = slow_grp_q;
  assign fast_pulses_o   = fast_q;
  assign slow_pulses_o   = slow_q;

  // A search never ends while an earlier result is still waiting inside
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    srch_res.done |-> !fin_q)
    else $error("search finished over an undelivered result");

  // A tick item is finished in the cycle after acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick |=> fin_q)
    else $error("tick item did not finish in one cycle");

  // A waiting result is held while the output register is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_q && out_valid_q && !out_ready_i) |=> fin_q && !in_ready_o)
    else $error("waiting result dropped under a stall");

endmodule

`default_nettype wire
